// File: hw/rtl/cubeuv_pkg.sv
package cubeuv_pkg;

  localparam int FACE_W  = 3;
  localparam int COORD_W = 17;
  localparam int DIR_W   = 16;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

endpackage

// File: hw/rtl/cubeuv_front.sv
module cubeuv_front
  import cubeuv_pkg::*;
#(
  parameter int C = 16,
  parameter int F = 14,
  localparam int SW = 2*C+3,
  localparam int WQ = 2*C+2*F+5
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [FACE_W-1:0]     face,
  input  logic [COORD_W-1:0]    u_coord,
  input  logic [COORD_W-1:0]    v_coord,
  output logic [SW-1:0]         s,
  output logic [2:0][WQ-1:0]    t,
  output logic [2:0]            sgn
);

  localparam int UW = C+19;
  localparam int AW = C+2;
  localparam int MW = C+1;
  localparam int PW = 2*C+2;

  logic [UW-1:0] one_c;
  logic [UW-1:0] u_ext, v_ext, u_sat, v_sat;
  logic signed [AW-1:0] a_val, b_val, f_val;
  logic signed [AW-1:0] vx, vy, vz;
  logic signed [2:0][AW-1:0] vec;
  logic [2:0][MW-1:0] mag;
  logic [2:0][PW-1:0] sq;
  logic [2:0] sgn_b;

  always_comb begin
    one_c = UW'(1) << C;
    u_ext = UW'(u_coord);
    v_ext = UW'(v_coord);
    u_sat = (u_ext > one_c) ? one_c : u_ext;
    v_sat = (v_ext > one_c) ? one_c : v_ext;
    a_val = $signed(AW'({u_sat, 1'b0} - {1'b0, one_c}));
    b_val = $signed(AW'({v_sat, 1'b0} - {1'b0, one_c}));
    f_val = $signed(AW'(one_c));
    case (face)
      FACE_POS_X: begin vx = f_val;  vy = -b_val; vz = -a_val; end
      FACE_NEG_X: begin vx = -f_val; vy = -b_val; vz = a_val;  end
      FACE_POS_Y: begin vx = a_val;  vy = f_val;  vz = b_val;  end
      FACE_NEG_Y: begin vx = a_val;  vy = -f_val; vz = -b_val; end
      FACE_NEG_Z: begin vx = -a_val; vy = -b_val; vz = -f_val; end
      default:    begin vx = a_val;  vy = -b_val; vz = f_val;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec[0] <= vx;
      vec[1] <= vy;
      vec[2] <= vz;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][AW-1] ? MW'(-vec[i]) : MW'(vec[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]    <= PW'(mag[i]) * PW'(mag[i]);
        sgn_b[i] <= vec[i][AW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        t[i] <= WQ'(sq[i]) << (2*F+2);
      end
      sgn <= sgn_b;
    end
  end

endmodule

// File: hw/rtl/cubeuv_cell.sv
module cubeuv_cell
  import cubeuv_pkg::*;
#(
  parameter int C = 16,
  parameter int F = 14,
  parameter int K = 0,
  localparam int SW = 2*C+3,
  localparam int WQ = 2*C+2*F+5,
  localparam int WA = WQ+2
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [SW-1:0]               s_in,
  input  logic [2:0][WQ-1:0]          t_in,
  input  logic [2:0]                  sgn_in,
  input  logic [2:0][F:0]             r_in,
  input  logic signed [2:0][WA-1:0]   q_in,
  input  logic signed [2:0][WA-1:0]   p_in,
  output logic [SW-1:0]               s_out,
  output logic [2:0][WQ-1:0]          t_out,
  output logic [2:0]                  sgn_out,
  output logic [2:0][F:0]             r_out,
  output logic signed [2:0][WA-1:0]   q_out,
  output logic signed [2:0][WA-1:0]   p_out
);

  logic signed [WA-1:0] s_w;
  logic signed [WA-1:0] trial [3];
  logic [2:0] take;

  // trial q' = q + 2^(K+1): q'^2 S = q^2 S + 2^(K+2) qS + 2^(2K+2) S
  always_comb begin
    s_w = $signed(WA'(s_in));
    for (int i = 0; i < 3; i++) begin
      trial[i] = q_in[i] + (p_in[i] <<< (K+2)) + (s_w <<< (2*K+2));
      take[i]  = !r_in[i][F] && (trial[i] <= $signed(WA'(t_in[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_out   <= s_in;
      t_out   <= t_in;
      sgn_out <= sgn_in;
      for (int i = 0; i < 3; i++) begin
        if (take[i]) begin
          r_out[i] <= r_in[i] | ((F+1)'(1) << K);
          q_out[i] <= trial[i];
          p_out[i] <= p_in[i] + (s_w <<< (K+1));
        end else begin
          r_out[i] <= r_in[i];
          q_out[i] <= q_in[i];
          p_out[i] <= p_in[i];
        end
      end
    end
  end

endmodule

// File: hw/rtl/cubemap_uv_to_direction.sv
// Cube map face coordinate to unit direction vector.
//
// Input channel: face, u_coord, v_coord with in_valid / in_stall. An item is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: dir_x, dir_y, dir_z with out_valid / out_stall, same rule.
// Each item yields exactly one unit vector, 2^OUT_FRAC_BITS meaning 1.0,
// rounded to nearest with ties away from zero.
//
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline is three front stages (face mux, squares, sum), one cell per
// result bit in the rounding search, and the output register.
//
// Reset (rst, synchronous) empties the pipeline; out_valid drops.
// When the receiver stalls, the result holds and upstream stages keep
// filling any empty slots; in_stall rises only once every stage is full.
module cubemap_uv_to_direction
  import cubeuv_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FACE_W-1:0]        face,
  input  logic [COORD_W-1:0]       u_coord,
  input  logic [COORD_W-1:0]       v_coord,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DIR_W-1:0]  dir_x,
  output logic signed [DIR_W-1:0]  dir_y,
  output logic signed [DIR_W-1:0]  dir_z
);

  localparam int C  = COORD_FRAC_BITS;
  localparam int F  = OUT_FRAC_BITS;
  localparam int NC = F+1;
  localparam int NS = NC+4;
  localparam int SW = 2*C+3;
  localparam int WQ = 2*C+2*F+5;
  localparam int WA = WQ+2;

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  assign adv[NS-1] = !vld[NS-1] || !out_stall;
  genvar g;
  generate
    for (g = 0; g < NS-1; g++) begin : g_adv
      assign adv[g] = !vld[g] || adv[g+1];
    end
  endgenerate

  assign in_stall  = !adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  logic [SW-1:0]             s_ch   [NC+1];
  logic [2:0][WQ-1:0]        t_ch   [NC+1];
  logic [2:0]                sgn_ch [NC+1];
  logic [2:0][F:0]           r_ch   [NC+1];
  logic signed [2:0][WA-1:0] q_ch   [NC+1];
  logic signed [2:0][WA-1:0] p_ch   [NC+1];

  cubeuv_front #(.C(C), .F(F)) u_front (
    .clk     (clk),
    .en      ({adv[2] && vld[1], adv[1] && vld[0], adv[0] && in_valid}),
    .face    (face),
    .u_coord (u_coord),
    .v_coord (v_coord),
    .s       (s_ch[0]),
    .t       (t_ch[0]),
    .sgn     (sgn_ch[0])
  );

  // start the search at r = 0, i.e. q = -1: Q = S, P = -S
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_ch[0][i] = '0;
      q_ch[0][i] = $signed(WA'(s_ch[0]));
      p_ch[0][i] = -$signed(WA'(s_ch[0]));
    end
  end

  generate
    for (g = 0; g < NC; g++) begin : g_cell
      cubeuv_cell #(.C(C), .F(F), .K(F-g)) u_cell (
        .clk     (clk),
        .en      (adv[g+3] && vld[g+2]),
        .s_in    (s_ch[g]),
        .t_in    (t_ch[g]),
        .sgn_in  (sgn_ch[g]),
        .r_in    (r_ch[g]),
        .q_in    (q_ch[g]),
        .p_in    (p_ch[g]),
        .s_out   (s_ch[g+1]),
        .t_out   (t_ch[g+1]),
        .sgn_out (sgn_ch[g+1]),
        .r_out   (r_ch[g+1]),
        .q_out   (q_ch[g+1]),
        .p_out   (p_ch[g+1])
      );
    end
  endgenerate

  logic signed [F+1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = sgn_ch[NC][i] ? -$signed({1'b0, r_ch[NC][i]})
                              : $signed({1'b0, r_ch[NC][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1] && vld[NS-2]) begin
      dir_x <= DIR_W'(comp[0]);
      dir_y <= DIR_W'(comp[1]);
      dir_z <= DIR_W'(comp[2]);
    end
  end

endmodule

// File: hw/rtl/cubeuv_checker.sv
module cubeuv_checker
  import cubeuv_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DIR_W-1:0]  dir_x,
  input logic signed [DIR_W-1:0]  dir_y,
  input logic signed [DIR_W-1:0]  dir_z
);

  localparam int LIM = (OUT_FRAC_BITS > 14) ? 16384 : (1 << OUT_FRAC_BITS);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dir_x) && $stable(dir_y)
      && $stable(dir_z))
    else $error("stalled item changed");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (OUT_FRAC_BITS > 14) ||
      (dir_x <= LIM && dir_x >= -LIM && dir_y <= LIM && dir_y >= -LIM
       && dir_z <= LIM && dir_z >= -LIM))
    else $error("component beyond unit length");

endmodule

bind cubemap_uv_to_direction cubeuv_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chk (.*);
